[rtl/dirty_rect_merge_tracker_defines.svh]
// Assertion macros shared by the dirty rectangle tracker RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef DIRTY_RECT_MERGE_TRACKER_DEFINES_SVH
`define DIRTY_RECT_MERGE_TRACKER_DEFINES_SVH

// Check that a condition implies a second one in the same cycle.
`define DRMT_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// Check that a condition implies a second one in the next cycle.
`define DRMT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

[rtl/drmt_pkg.sv]
// Types, constants and action codes of the dirty rectangle tracker.
// Depends on nothing; imported by the tracker top level and the touch unit.
package drmt_pkg;

   localparam int RECT_CAPACITY = 16;
   localparam int REASON_BITS   = 8;
   localparam int COORD_BITS    = 16;
   localparam int PAD_BITS      = 8;
   localparam int TOTAL_BITS    = 32;
   localparam int EXT_BITS      = COORD_BITS + 1;
   localparam int IDX_BITS      = (RECT_CAPACITY > 1) ? $clog2(RECT_CAPACITY) : 1;
   localparam int COUNT_BITS    = $clog2(RECT_CAPACITY + 1);

   localparam logic [PAD_BITS-1:0] PAD_RESET = PAD_BITS'(8);

   // action codes
   localparam logic [2:0] ACT_MARK      = 3'd0;
   localparam logic [2:0] ACT_MARK_RECT = 3'd1;
   localparam logic [2:0] ACT_CLEAR     = 3'd2;
   localparam logic [2:0] ACT_CONSUME   = 3'd3;
   localparam logic [2:0] ACT_SNAPSHOT  = 3'd4;
   localparam logic [2:0] ACT_QUERY     = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] bottom;
   } box_type;

   localparam int BOX_BITS = $bits(box_type);

   typedef struct packed {
      logic [2:0]                   action;
      logic [REASON_BITS-1:0]       reason;
      logic signed [COORD_BITS-1:0] rect_left;
      logic signed [COORD_BITS-1:0] rect_top;
      logic signed [COORD_BITS-1:0] rect_right;
      logic signed [COORD_BITS-1:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic                         out_valid_rect;
      logic signed [COORD_BITS-1:0] out_left;
      logic signed [COORD_BITS-1:0] out_top;
      logic signed [COORD_BITS-1:0] out_right;
      logic signed [COORD_BITS-1:0] out_bottom;
      logic [REASON_BITS-1:0]       dirty_flags;
      logic                         any_dirty;
      logic                         has_reason;
      logic [TOTAL_BITS-1:0]        marks_total;
      logic [TOTAL_BITS-1:0]        consumes_total;
      logic [TOTAL_BITS-1:0]        merges_total;
      logic                         last;
   } rsp_type;

   // result of one touch test against a stored rectangle
   typedef struct packed {
      logic    touch;
      box_type grown;
   } touch_type;

endpackage

[rtl/dirty_rect_merge_tracker.sv]
// Channel  | Direction | Handshake         | Carries
// req_     | in        | req_valid / stall | drmt_pkg::req_type, one action
// rsp_     | out       | rsp_valid / stall | drmt_pkg::rsp_type, one result
// csr_     | in        | csr_valid / ready | touch padding, 8 bits
//
// mark_rect scans the stored rectangles one at a time, or writes straight into an empty
// table; the scan is paced by the single touch unit and the registered RAM read.
// snapshot and consume give one result per stored rectangle, or one for an empty table.
// Reset (synchronous, active high) clears flags, count and counters; padding goes to 8.
// A stalled result holds in the output register; the sequencer waits on it.
// Top level of the dirty rectangle tracker; depends on drmt_pkg, drmt_ram,
// drmt_touch_unit and dirty_rect_merge_tracker_defines.svh.
`include "dirty_rect_merge_tracker_defines.svh"

module dirty_rect_merge_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  drmt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output drmt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [drmt_pkg::PAD_BITS-1:0] csr_data
);
   import drmt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SCAN_ADDR,
      ST_SCAN_CMP,
      ST_DUMP_ADDR,
      ST_DUMP_EMIT,
      ST_EMIT_ONE
   } state_type;

   state_type               state_ff, state_in;
   req_type                 cur_ff, cur_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [REASON_BITS-1:0]  flags_ff, flags_in;
   logic [TOTAL_BITS-1:0]   marks_ff, marks_in;
   logic [TOTAL_BITS-1:0]   consumes_ff, consumes_in;
   logic [TOTAL_BITS-1:0]   merges_ff, merges_in;
   logic [PAD_BITS-1:0]     pad_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   box_type                 wr_box;
   logic [BOX_BITS-1:0]     rd_bits;
   box_type                 rd_box;
   box_type                 cur_box;
   touch_type               touch;
   logic                    out_free;
   logic                    at_end;
   logic                    load;
   logic                    load_rect;
   logic                    load_last;
   logic                    req_nonempty;
   logic                    visit_state;
   logic                    consume_end;

   // rectangle table
   drmt_ram #(
      .WIDTH (BOX_BITS),
      .DEPTH (RECT_CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_box),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   assign rd_box = rd_bits;
   assign cur_box = '{left: cur_ff.rect_left, top: cur_ff.rect_top,
                      right: cur_ff.rect_right, bottom: cur_ff.rect_bottom};

   drmt_touch_unit u_touch (
      .stored   (rd_box),
      .incoming (cur_box),
      .pad      (pad_ff),
      .result   (touch)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign at_end       = (COUNT_BITS'(idx_ff) == count_ff - COUNT_BITS'(1));
   assign req_nonempty = (req_data.rect_right > req_data.rect_left) &&
                         (req_data.rect_bottom > req_data.rect_top);

   // sequence one transaction through scan, update and emit steps
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      flags_in    = flags_ff;
      marks_in    = marks_ff;
      consumes_in = consumes_ff;
      merges_in   = merges_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_box      = touch.grown;
      load        = 1'b0;
      load_rect   = 1'b0;
      load_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_data;
               idx_in = '0;
               case (req_data.action)
                  ACT_MARK: begin
                     flags_in = flags_ff | req_data.reason;
                     marks_in = marks_ff + TOTAL_BITS'(1);
                     state_in = ST_EMIT_ONE;
                  end
                  ACT_MARK_RECT: begin
                     flags_in = flags_ff | req_data.reason;
                     marks_in = marks_ff + TOTAL_BITS'(1);
                     if (!req_nonempty) begin
                        state_in = ST_EMIT_ONE;
                     end else if (count_ff == '0) begin
                        state_in = ST_APPEND;
                     end else begin
                        state_in = ST_SCAN_ADDR;
                     end
                  end
                  ACT_CLEAR: begin
                     flags_in = '0;
                     count_in = '0;
                     state_in = ST_EMIT_ONE;
                  end
                  ACT_CONSUME, ACT_SNAPSHOT: begin
                     state_in = (count_ff == '0) ? ST_EMIT_ONE : ST_DUMP_ADDR;
                  end
                  default: begin
                     state_in = ST_EMIT_ONE;
                  end
               endcase
            end
         end
         ST_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_BITS-1:0];
            wr_box   = cur_box;
            count_in = count_ff + COUNT_BITS'(1);
            state_in = ST_EMIT_ONE;
         end
         ST_SCAN_ADDR: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (touch.touch) begin
               wr_en     = 1'b1;
               merges_in = merges_ff + TOTAL_BITS'(1);
               state_in  = ST_EMIT_ONE;
            end else if (at_end) begin
               wr_en = 1'b1;
               if (count_ff < COUNT_BITS'(RECT_CAPACITY)) begin
                  wr_addr  = count_ff[IDX_BITS-1:0];
                  wr_box   = cur_box;
                  count_in = count_ff + COUNT_BITS'(1);
               end else begin
                  // table full: fold into the last entry
                  merges_in = merges_ff + TOTAL_BITS'(1);
               end
               state_in = ST_EMIT_ONE;
            end else begin
               idx_in   = idx_ff + IDX_BITS'(1);
               state_in = ST_SCAN_ADDR;
            end
         end
         ST_DUMP_ADDR: begin
            state_in = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (out_free) begin
               load      = 1'b1;
               load_rect = 1'b1;
               load_last = at_end;
               if (at_end) begin
                  if (cur_ff.action == ACT_CONSUME) begin
                     consumes_in = consumes_ff + TOTAL_BITS'(1);
                     flags_in    = '0;
                     count_in    = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_BITS'(1);
                  state_in = ST_DUMP_ADDR;
               end
            end
         end
         ST_EMIT_ONE: begin
            if (out_free) begin
               load = 1'b1;
               // a consume of an empty table still counts and drops the flags
               if (cur_ff.action == ACT_CONSUME) begin
                  consumes_in = consumes_ff + TOTAL_BITS'(1);
                  flags_in    = '0;
                  count_in    = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // build the result from the current status
   always_comb begin
      rsp_data_in                = rsp_data_ff;
      rsp_valid_in               = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.out_valid_rect = load_rect;
         rsp_data_in.out_left       = load_rect ? rd_box.left : '0;
         rsp_data_in.out_top        = load_rect ? rd_box.top : '0;
         rsp_data_in.out_right      = load_rect ? rd_box.right : '0;
         rsp_data_in.out_bottom     = load_rect ? rd_box.bottom : '0;
         rsp_data_in.dirty_flags    = flags_ff;
         rsp_data_in.any_dirty      = (flags_ff != '0) || (count_ff != '0);
         rsp_data_in.has_reason     = |(flags_ff & cur_ff.reason);
         rsp_data_in.marks_total    = marks_ff;
         rsp_data_in.consumes_total = consumes_ff;
         rsp_data_in.merges_total   = merges_ff;
         rsp_data_in.last           = load_last;
      end
   end

   // hold state, counters and the output register
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         flags_ff     <= '0;
         marks_ff     <= '0;
         consumes_ff  <= '0;
         merges_ff    <= '0;
         pad_ff       <= PAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         marks_ff     <= marks_in;
         consumes_ff  <= consumes_in;
         merges_ff    <= merges_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            pad_ff <= csr_data;
         end
      end
   end

   assign visit_state = (state_ff == ST_SCAN_CMP) || (state_ff == ST_DUMP_EMIT);
   assign consume_end = load && load_last && (cur_ff.action == ACT_CONSUME);

   // table never holds more than its capacity
   `DRMT_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_BITS'(RECT_CAPACITY))

   // scan and dump only visit stored entries
   `DRMT_ASSERT_SAME(a_idx_stored, clock, reset, visit_state, COUNT_BITS'(idx_ff) < count_ff)

   // final consume result empties the tracker
   `DRMT_ASSERT_NEXT(a_consume_clears, clock, reset, consume_end, (count_ff == '0) && (flags_ff == '0))

endmodule

[rtl/drmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the rectangle table of the tracker.
module drmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/drmt_touch_unit.sv]
// Shared touch test and bounding-box unit, applied to one stored rectangle at a time.
// Depends on drmt_pkg.
module drmt_touch_unit (
   input  drmt_pkg::box_type              stored,
   input  drmt_pkg::box_type              incoming,
   input  logic [drmt_pkg::PAD_BITS-1:0]  pad,
   output drmt_pkg::touch_type            result
);
   import drmt_pkg::*;

   logic signed [EXT_BITS-1:0] pad_ext;
   logic signed [EXT_BITS-1:0] s_l, s_t, s_r, s_b;
   logic signed [EXT_BITS-1:0] n_l, n_t, n_r, n_b;
   logic                       apart;

   // widen by one bit so edge plus padding cannot overflow
   assign pad_ext = signed'({{(EXT_BITS - PAD_BITS){1'b0}}, pad});
   assign s_l = signed'({stored.left[COORD_BITS-1], stored.left});
   assign s_t = signed'({stored.top[COORD_BITS-1], stored.top});
   assign s_r = signed'({stored.right[COORD_BITS-1], stored.right});
   assign s_b = signed'({stored.bottom[COORD_BITS-1], stored.bottom});
   assign n_l = signed'({incoming.left[COORD_BITS-1], incoming.left});
   assign n_t = signed'({incoming.top[COORD_BITS-1], incoming.top});
   assign n_r = signed'({incoming.right[COORD_BITS-1], incoming.right});
   assign n_b = signed'({incoming.bottom[COORD_BITS-1], incoming.bottom});

   // separated on some side by more than the padding
   assign apart = (s_r + pad_ext < n_l) || (n_r + pad_ext < s_l) ||
                  (s_b + pad_ext < n_t) || (n_b + pad_ext < s_t);

   // bounding box of both
   always_comb begin
      result.touch         = !apart;
      result.grown.left    = (incoming.left < stored.left) ? incoming.left : stored.left;
      result.grown.top     = (incoming.top < stored.top) ? incoming.top : stored.top;
      result.grown.right   = (incoming.right > stored.right) ? incoming.right : stored.right;
      result.grown.bottom  = (incoming.bottom > stored.bottom) ? incoming.bottom : stored.bottom;
   end

endmodule

[sim/drmt_result_checker.sv]
// Result checker for the dirty rectangle tracker: watches the request, result and
// padding channels, predicts every result and compares it field by field.
// Depends on drmt_pkg for the channel payload types and action codes.
module drmt_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  drmt_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  drmt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [drmt_pkg::PAD_BITS-1:0] csr_data,
   output int                            fail_count,
   output int                            pending_results
);
   import drmt_pkg::*;

   localparam int PRINT_CAP = 200;

   // predicted tracker state
   logic [PAD_BITS-1:0]    touch_pad;
   logic [REASON_BITS-1:0] flag_bits;
   box_type                rect_store [RECT_CAPACITY];
   int                     rect_used;
   logic [TOTAL_BITS-1:0]  mark_total;
   logic [TOTAL_BITS-1:0]  consume_total;
   logic [TOTAL_BITS-1:0]  merge_total;

   rsp_type expected_results [$];
   int      mismatch_count = 0;
   int      pending_count = 0;

   assign fail_count      = mismatch_count;
   assign pending_results = pending_count;

   // Build the status part of a result from the current state.
   function automatic rsp_type status_of(logic [REASON_BITS-1:0] reason);
      rsp_type s;
      s = '0;
      s.dirty_flags    = flag_bits;
      s.any_dirty      = (flag_bits != '0) || (rect_used != 0);
      s.has_reason     = (flag_bits & reason) != '0;
      s.marks_total    = mark_total;
      s.consumes_total = consume_total;
      s.merges_total   = merge_total;
      s.last           = 1'b1;
      return s;
   endfunction

   // Queue one expected result behind the ones already waiting.
   task automatic expect_result(rsp_type s);
      expected_results = {expected_results, s};
   endtask

   // Touch test at full precision: padding applies on every side.
   function automatic bit near(box_type a, int l, int t, int r, int b);
      int al, at, ar, ab, pad;
      al  = a.left;
      at  = a.top;
      ar  = a.right;
      ab  = a.bottom;
      pad = touch_pad;
      return !(ar + pad < l || r + pad < al || ab + pad < t || b + pad < at);
   endfunction

   // Grow a stored rectangle to the bounding box of itself and the new one.
   task automatic grow_entry(int idx, int l, int t, int r, int b);
      int al, at, ar, ab;
      al = rect_store[idx].left;
      at = rect_store[idx].top;
      ar = rect_store[idx].right;
      ab = rect_store[idx].bottom;
      if (l < al) rect_store[idx].left = 16'(l);
      if (t < at) rect_store[idx].top = 16'(t);
      if (r > ar) rect_store[idx].right = 16'(r);
      if (b > ab) rect_store[idx].bottom = 16'(b);
      merge_total++;
   endtask

   // Advance the predicted state by one request and queue its results.
   task automatic apply_action(req_type r);
      rsp_type s;
      int      l, t, rr, b, i;
      bit      placed;
      case (r.action)
         ACT_MARK, ACT_MARK_RECT: begin
            flag_bits = flag_bits | r.reason;
            mark_total++;
            l  = r.rect_left;
            t  = r.rect_top;
            rr = r.rect_right;
            b  = r.rect_bottom;
            // an empty rectangle only marks
            if (r.action == ACT_MARK_RECT && rr > l && b > t) begin
               placed = 1'b0;
               for (i = 0; i < rect_used && !placed; i++) begin
                  if (near(rect_store[i], l, t, rr, b)) begin
                     grow_entry(i, l, t, rr, b);
                     placed = 1'b1;
                  end
               end
               if (!placed) begin
                  if (rect_used < RECT_CAPACITY) begin
                     rect_store[rect_used] = '{16'(l), 16'(t), 16'(rr), 16'(b)};
                     rect_used++;
                  end else begin
                     // full table: fold into the last entry
                     grow_entry(RECT_CAPACITY - 1, l, t, rr, b);
                  end
               end
            end
            expect_result(status_of(r.reason));
         end
         ACT_CLEAR: begin
            flag_bits = '0;
            rect_used = 0;
            expect_result(status_of(r.reason));
         end
         ACT_CONSUME, ACT_SNAPSHOT: begin
            s = status_of(r.reason);
            if (rect_used == 0) begin
               expect_result(s);
            end else begin
               for (i = 0; i < rect_used; i++) begin
                  s.out_valid_rect = 1'b1;
                  s.out_left       = rect_store[i].left;
                  s.out_top        = rect_store[i].top;
                  s.out_right      = rect_store[i].right;
                  s.out_bottom     = rect_store[i].bottom;
                  s.last           = (i == rect_used - 1);
                  expect_result(s);
               end
            end
            if (r.action == ACT_CONSUME) begin
               consume_total++;
               flag_bits = '0;
               rect_used = 0;
            end
         end
         default: begin
            // query and the unused codes change nothing
            expect_result(status_of(r.reason));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("drmt mismatch: %s got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   // Compare one result transaction against the oldest expectation.
   task automatic check_result(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected", got.last, 0);
      end else begin
         want = expected_results.pop_front();
         if (got.out_valid_rect !== want.out_valid_rect)
            report_mismatch("out_valid_rect", got.out_valid_rect, want.out_valid_rect);
         if (got.out_left !== want.out_left)
            report_mismatch("out_left", got.out_left, want.out_left);
         if (got.out_top !== want.out_top)
            report_mismatch("out_top", got.out_top, want.out_top);
         if (got.out_right !== want.out_right)
            report_mismatch("out_right", got.out_right, want.out_right);
         if (got.out_bottom !== want.out_bottom)
            report_mismatch("out_bottom", got.out_bottom, want.out_bottom);
         if (got.dirty_flags !== want.dirty_flags)
            report_mismatch("dirty_flags", got.dirty_flags, want.dirty_flags);
         if (got.any_dirty !== want.any_dirty)
            report_mismatch("any_dirty", got.any_dirty, want.any_dirty);
         if (got.has_reason !== want.has_reason)
            report_mismatch("has_reason", got.has_reason, want.has_reason);
         if (got.marks_total !== want.marks_total)
            report_mismatch("marks_total", got.marks_total, want.marks_total);
         if (got.consumes_total !== want.consumes_total)
            report_mismatch("consumes_total", got.consumes_total, want.consumes_total);
         if (got.merges_total !== want.merges_total)
            report_mismatch("merges_total", got.merges_total, want.merges_total);
         if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
      end
   endtask

   // Retire results first, then pick up padding writes and new requests.
   always @(posedge clock) begin
      if (reset) begin
         touch_pad     = PAD_RESET;
         flag_bits     = '0;
         rect_used     = 0;
         mark_total    = '0;
         consume_total = '0;
         merge_total   = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_valid && csr_ready) touch_pad = csr_data;
         if (req_valid && !req_stall) apply_action(req_data);
      end
      pending_count <= expected_results.size();
   end

endmodule

[sim/dirty_rect_merge_tracker_tb.sv]
// Testbench top for the dirty rectangle tracker: drives actions and padding
// writes, throttles the result side and gives the verdict.
// Depends on drmt_pkg, dirty_rect_merge_tracker and drmt_result_checker.
module dirty_rect_merge_tracker_tb;
   import drmt_pkg::*;

   localparam logic [2:0] ACT_UNUSED_A    = 3'd6;
   localparam logic [2:0] ACT_UNUSED_B    = 3'd7;
   localparam int         CYCLE_LIMIT      = 500000;
   localparam int         HOLD_CYCLES      = 400;
   localparam int         RANDOM_PER_PHASE = 56;
   localparam int         PHASES           = 5;

   typedef enum logic [1:0] {
      FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC
   } flow_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PAD_BITS-1:0] csr_data = '0;

   int fail_count;
   int pending_results;
   int cycle_count = 0;
   int burst_left = 0;
   int items_sent = 0;

   // receiver throttle state
   int            hold_asks = 0;
   int            hold_seen = 0;
   int            hold_left = 0;
   int            pattern_left = 0;
   flow_mode_type flow_mode = FLOW_FREE;

   dirty_rect_merge_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   drmt_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dirty_rect_merge_tracker verification failed");
         $finish;
      end
   end

   // Throttle results: a long hold when asked, otherwise a changing stall pattern.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            flow_mode    <= flow_mode_type'($urandom_range(0, 3));
            pattern_left <= $urandom_range(16, 96);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (flow_mode)
            FLOW_FREE:     rsp_stall <= 1'b0;
            FLOW_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 6);
            FLOW_PERIODIC: rsp_stall <= (cycle_count % 3 == 0);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   function automatic req_type make_req(logic [2:0] action, logic [REASON_BITS-1:0] reason,
                                        int l, int t, int r, int b);
      req_type q;
      q.action      = action;
      q.reason      = reason;
      q.rect_left   = 16'(l);
      q.rect_top    = 16'(t);
      q.rect_right  = 16'(r);
      q.rect_bottom = 16'(b);
      return q;
   endfunction

   // Offer one request transaction in bursts with random gaps; return once accepted.
   task automatic send_action(req_type q);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_padding(logic [PAD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Marks around one spot, so that some touch and some do not, then a readout.
   task automatic run_cluster();
      int cx, cy, n, l, t, w, h;
      cx = int'($urandom_range(0, 60000)) - 30000;
      cy = int'($urandom_range(0, 60000)) - 30000;
      n  = $urandom_range(2, 8);
      repeat (n) begin
         l = cx + int'($urandom_range(0, 600)) - 300;
         t = cy + int'($urandom_range(0, 600)) - 300;
         w = int'($urandom_range(0, 220)) - 20;
         h = int'($urandom_range(0, 220)) - 20;
         send_action(make_req(ACT_MARK_RECT, 8'(1 << $urandom_range(0, 7)), l, t, l + w, t + h));
      end
      if ($urandom_range(0, 2) == 0)
         send_action(make_req(ACT_QUERY, 8'($urandom), 0, 0, 0, 0));
      send_action(make_req($urandom_range(0, 1) ? ACT_CONSUME : ACT_SNAPSHOT,
                           8'($urandom), 0, 0, 0, 0));
   endtask

   // Disjoint rectangles on a coarse grid, enough to fill the table and at times overflow it.
   task automatic run_fill();
      int first_slot, n, grid_slot, i, l, t;
      first_slot = $urandom_range(0, 255);
      n          = $urandom_range(16, 20);
      for (i = 0; i < n; i++) begin
         grid_slot = (first_slot + i * 7) % 256;
         l = -32768 + (grid_slot % 16) * 4096 + int'($urandom_range(0, 1000));
         t = -32768 + (grid_slot / 16) * 4096 + int'($urandom_range(0, 1000));
         send_action(make_req(ACT_MARK_RECT, 8'($urandom), l, t,
                              l + int'($urandom_range(1, 2000)),
                              t + int'($urandom_range(1, 2000))));
      end
      send_action(make_req($urandom_range(0, 1) ? ACT_CONSUME : ACT_SNAPSHOT,
                           8'($urandom), 0, 0, 0, 0));
   endtask

   // Fully random fields, every action code included.
   task automatic run_noise();
      req_type q;
      repeat ($urandom_range(1, 4)) begin
         q.action      = 3'($urandom_range(0, 7));
         q.reason      = 8'($urandom);
         q.rect_left   = 16'($urandom);
         q.rect_top    = 16'($urandom);
         q.rect_right  = 16'($urandom);
         q.rect_bottom = 16'($urandom);
         send_action(q);
      end
   endtask

   task automatic run_random(int count);
      int end_count, pick;
      end_count = items_sent + count;
      run_fill();
      while (items_sent < end_count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) run_cluster();
         else if (pick < 7) run_fill();
         else run_noise();
      end
   endtask

   initial begin
      int pad_plan [PHASES];
      int phase;
      pad_plan = '{0, 255, 1, 0, 40};
      pad_plan[3] = $urandom_range(2, 254);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty readouts, empty rectangles, touch boundary, extremes
      send_action(make_req(ACT_QUERY, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_SNAPSHOT, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_CONSUME, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_MARK, 8'h01, 0, 0, 0, 0));
      send_action(make_req(ACT_MARK_RECT, 8'h80, 5, 5, 5, 20));
      send_action(make_req(ACT_MARK_RECT, 8'h02, 5, 20, 10, 5));
      send_action(make_req(ACT_MARK_RECT, 8'h04, 0, 0, 10, 10));
      send_action(make_req(ACT_MARK_RECT, 8'h00, 18, 18, 30, 30));
      send_action(make_req(ACT_MARK_RECT, 8'h10, 100, 100, 110, 110));
      send_action(make_req(ACT_MARK_RECT, 8'h00, 119, 100, 130, 110));
      send_action(make_req(ACT_MARK_RECT, 8'h00, -32768, -32768, -32760, -32760));
      send_action(make_req(ACT_MARK_RECT, 8'h00, 32760, 32760, 32767, 32767));
      send_action(make_req(ACT_QUERY, 8'h80, 0, 0, 0, 0));
      send_action(make_req(ACT_QUERY, 8'h40, 0, 0, 0, 0));
      send_action(make_req(ACT_UNUSED_A, 8'hFF, 1, 2, 3, 4));
      send_action(make_req(ACT_UNUSED_B, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_SNAPSHOT, 8'h05, 0, 0, 0, 0));
      send_action(make_req(ACT_MARK_RECT, 8'h20, -32768, -32768, 32767, 32767));
      send_action(make_req(ACT_SNAPSHOT, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_CONSUME, 8'hFF, 0, 0, 0, 0));
      send_action(make_req(ACT_QUERY, 8'hFF, 0, 0, 0, 0));
      send_action(make_req(ACT_MARK, 8'hFF, 0, 0, 0, 0));
      send_action(make_req(ACT_CLEAR, 8'h00, 0, 0, 0, 0));
      send_action(make_req(ACT_QUERY, 8'hFF, 0, 0, 0, 0));

      // random phases, each under its own padding
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         write_padding(8'(pad_plan[phase]));
         // hold the result side off long enough to back the block up
         if (phase == 1) hold_asks <= hold_asks + 1;
         run_random(RANDOM_PER_PHASE);
      end

      settle();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("dirty_rect_merge_tracker verification clean");
      else
         $display("dirty_rect_merge_tracker verification failed");
      $finish;
   end

endmodule
